// ----- rtl/jpsc_pkg.sv -----
// ----------------------------------------------------------------------------
// jpsc_pkg
// Shared types, constants and micro-op tables of the plane singularity counter.
// ----------------------------------------------------------------------------
package jpsc_pkg;

    localparam int MAX_SEGMENTS_DEF = 8;
    localparam int COL_W     = 16;
    localparam int CNT_W     = 5;
    localparam int IDX_W     = 5;
    localparam int SEGS_W    = 4;
    localparam int THR_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;
    localparam int SEG_IDX_W = 4;
    localparam int MUL_W     = 33;
    localparam int NRM_W     = 33;
    localparam int NSQ_W     = 32;
    localparam int PRD_W     = 64;
    localparam int ACC_W     = 67;
    localparam int Q_W       = 128;
    localparam int WIDE_W    = 160;
    localparam int STEP_W    = 4;
    localparam int SEQ_LEN   = 15;

    localparam logic [SEGS_W-1:0] SEGS_RESET = 4'd3;
    localparam logic [THR_W-1:0]  THR_RESET  = 16'd32604;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SEGMENT_COUNT      = 1'b0,
        REG_PARALLEL_THRESHOLD = 1'b1
    } cfg_reg_t;

    typedef enum logic [4:0] {
        UOP_NOP, UOP_NX0, UOP_NX1, UOP_NY0, UOP_NY1, UOP_NZ0, UOP_NZ1,
        UOP_NA0, UOP_NA1, UOP_NA2, UOP_NB0, UOP_NB1, UOP_NB2, UOP_PP, UOP_WR,
        UOP_D0, UOP_D1, UOP_D2, UOP_Q00, UOP_Q01, UOP_Q10, UOP_Q11,
        UOP_M00, UOP_M01, UOP_M10, UOP_M11, UOP_T0, UOP_T1, UOP_T2, UOP_T3
    } uop_t;

    typedef struct packed {
        uop_t                 uop;
        logic                 load;
        logic                 emit;
        logic [SEG_IDX_W-1:0] k;
    } jpsc_cmd_t;

    typedef struct packed {
        logic                 build;
        logic                 last;
        logic [SEG_IDX_W-1:0] seg;
    } jpsc_status_t;

    // normal, squared norms, then norm product and store
    function automatic uop_t build_uop(input logic [STEP_W-1:0] step);
        uop_t u;
        case (step)
            4'd0:    u = UOP_NX0;
            4'd1:    u = UOP_NX1;
            4'd2:    u = UOP_NY0;
            4'd3:    u = UOP_NY1;
            4'd4:    u = UOP_NZ0;
            4'd5:    u = UOP_NZ1;
            4'd6:    u = UOP_NA0;
            4'd7:    u = UOP_NA1;
            4'd8:    u = UOP_NA2;
            4'd9:    u = UOP_NB0;
            4'd10:   u = UOP_NB1;
            4'd11:   u = UOP_NB2;
            4'd13:   u = UOP_PP;
            4'd14:   u = UOP_WR;
            default: u = UOP_NOP;
        endcase
        return u;
    endfunction

    // dot product, norm product, squared dot, threshold scaling and compare
    function automatic uop_t cmp_uop(input logic [STEP_W-1:0] step);
        uop_t u;
        case (step)
            4'd0:    u = UOP_D0;
            4'd1:    u = UOP_D1;
            4'd2:    u = UOP_D2;
            4'd3:    u = UOP_Q00;
            4'd4:    u = UOP_Q01;
            4'd5:    u = UOP_Q10;
            4'd6:    u = UOP_Q11;
            4'd7:    u = UOP_M00;
            4'd8:    u = UOP_M01;
            4'd9:    u = UOP_M10;
            4'd10:   u = UOP_M11;
            4'd11:   u = UOP_T0;
            4'd12:   u = UOP_T1;
            4'd13:   u = UOP_T2;
            4'd14:   u = UOP_T3;
            default: u = UOP_NOP;
        endcase
        return u;
    endfunction

endpackage

// ----- rtl/jpsc_if.sv -----
// ----------------------------------------------------------------------------
// jpsc_if
// Valid/ready channels for Jacobian columns and pair counts.
// ----------------------------------------------------------------------------
interface jpsc_col_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] col_x;
    logic signed [15:0] col_y;
    logic signed [15:0] col_z;
    logic               last_column;

    modport source (output valid, col_x, col_y, col_z, last_column, input ready);
    modport sink   (input valid, col_x, col_y, col_z, last_column, output ready);
endinterface

interface jpsc_cnt_if;
    logic       valid;
    logic       ready;
    logic [4:0] pair_count;

    modport source (output valid, pair_count, input ready);
    modport sink   (input valid, pair_count, output ready);
endinterface

// ----- rtl/jpsc_datapath.sv -----
// ----------------------------------------------------------------------------
// jpsc_datapath
// Column registers, normal store, shared multiplier and wide compare.
// ----------------------------------------------------------------------------
module jpsc_datapath
    import jpsc_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
)(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic signed [COL_W-1:0] col_x,
    input  logic signed [COL_W-1:0] col_y,
    input  logic signed [COL_W-1:0] col_z,
    input  logic                    last_column,
    input  jpsc_cmd_t               cmd,
    output jpsc_status_t            st,
    output logic [CNT_W-1:0]        pair_count
);

    localparam int SW = $clog2(MAX_SEGMENTS);
    localparam logic [IDX_W-1:0] SEGS_CAP = IDX_W'(MAX_SEGMENTS);

    // configuration
    logic [SEGS_W-1:0] segs_reg, segs_next;
    logic [THR_W-1:0]  thr_reg, thr_next;
    logic [31:0]       t2_reg;

    // frame state
    logic [IDX_W-1:0]  index_reg, index_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic signed [COL_W-1:0] hx_reg, hy_reg, hz_reg, hx_next, hy_next, hz_next;
    logic signed [COL_W-1:0] cx_reg, cy_reg, cz_reg, cx_next, cy_next, cz_next;
    logic              last_reg, last_next;
    logic [SW-1:0]     seg_reg, seg_next;
    logic [CNT_W-1:0]  out_reg, out_next;

    // arithmetic
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] mul_p_reg, mul_p_next;
    uop_t                      op_reg;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [NRM_W-1:0]   nx_reg, ny_reg, nz_reg, nx_next, ny_next, nz_next;
    logic [NSQ_W-1:0]          na_reg, nb_reg, na_next, nb_next;
    logic [PRD_W-1:0]          cp_reg, cp_next;
    logic [PRD_W-1:0]          mag_reg, mag_next;
    logic [WIDE_W-1:0]         wacc_reg, wacc_next;
    logic [Q_W-1:0]            q_reg, q_next;
    logic [WIDE_W-1:0]         lhs_reg, lhs_next;

    // normal store, one read port at the compare index
    logic signed [NRM_W-1:0] mem_nx [MAX_SEGMENTS];
    logic signed [NRM_W-1:0] mem_ny [MAX_SEGMENTS];
    logic signed [NRM_W-1:0] mem_nz [MAX_SEGMENTS];
    logic [PRD_W-1:0]        mem_p  [MAX_SEGMENTS];

    logic [IDX_W-1:0]  seg_ext, segs_eff;
    logic              in_range;
    logic [SW-1:0]     rd_k;

    assign seg_ext  = {1'b0, segs_reg};
    assign segs_eff = (seg_ext > SEGS_CAP) ? SEGS_CAP : seg_ext;
    assign in_range = {1'b0, index_reg} < {segs_eff, 1'b0};
    assign rd_k     = cmd.k[SW-1:0];

    assign st.build    = in_range && index_reg[0];
    assign st.last     = last_reg;
    assign st.seg      = SEG_IDX_W'(seg_reg);
    assign pair_count  = out_reg;

    function automatic logic signed [MUL_W-1:0] sx(input logic signed [COL_W-1:0] v);
        return {{(MUL_W-COL_W){v[COL_W-1]}}, v};
    endfunction

    function automatic logic signed [MUL_W-1:0] zx(input logic [31:0] v);
        return {1'b0, v};
    endfunction

    always_comb
    begin
        case (cmd.uop)
            UOP_NX0: begin mul_a = sx(hy_reg); mul_b = sx(cz_reg); end
            UOP_NX1: begin mul_a = sx(hz_reg); mul_b = sx(cy_reg); end
            UOP_NY0: begin mul_a = sx(hz_reg); mul_b = sx(cx_reg); end
            UOP_NY1: begin mul_a = sx(hx_reg); mul_b = sx(cz_reg); end
            UOP_NZ0: begin mul_a = sx(hx_reg); mul_b = sx(cy_reg); end
            UOP_NZ1: begin mul_a = sx(hy_reg); mul_b = sx(cx_reg); end
            UOP_NA0: begin mul_a = sx(hx_reg); mul_b = sx(hx_reg); end
            UOP_NA1: begin mul_a = sx(hy_reg); mul_b = sx(hy_reg); end
            UOP_NA2: begin mul_a = sx(hz_reg); mul_b = sx(hz_reg); end
            UOP_NB0: begin mul_a = sx(cx_reg); mul_b = sx(cx_reg); end
            UOP_NB1: begin mul_a = sx(cy_reg); mul_b = sx(cy_reg); end
            UOP_NB2: begin mul_a = sx(cz_reg); mul_b = sx(cz_reg); end
            UOP_PP:  begin mul_a = zx(na_reg); mul_b = zx(nb_reg); end
            UOP_D0:  begin mul_a = mem_nx[rd_k]; mul_b = nx_reg; end
            UOP_D1:  begin mul_a = mem_ny[rd_k]; mul_b = ny_reg; end
            UOP_D2:  begin mul_a = mem_nz[rd_k]; mul_b = nz_reg; end
            UOP_Q00: begin mul_a = zx(mem_p[rd_k][31:0]);  mul_b = zx(cp_reg[31:0]);  end
            UOP_Q01: begin mul_a = zx(mem_p[rd_k][31:0]);  mul_b = zx(cp_reg[63:32]); end
            UOP_Q10: begin mul_a = zx(mem_p[rd_k][63:32]); mul_b = zx(cp_reg[31:0]);  end
            UOP_Q11: begin mul_a = zx(mem_p[rd_k][63:32]); mul_b = zx(cp_reg[63:32]); end
            UOP_M00: begin mul_a = zx(mag_reg[31:0]);  mul_b = zx(mag_reg[31:0]);  end
            UOP_M01: begin mul_a = zx(mag_reg[31:0]);  mul_b = zx(mag_reg[63:32]); end
            UOP_M10: begin mul_a = zx(mag_reg[63:32]); mul_b = zx(mag_reg[31:0]);  end
            UOP_M11: begin mul_a = zx(mag_reg[63:32]); mul_b = zx(mag_reg[63:32]); end
            UOP_T0:  begin mul_a = zx(q_reg[31:0]);   mul_b = zx(t2_reg); end
            UOP_T1:  begin mul_a = zx(q_reg[63:32]);  mul_b = zx(t2_reg); end
            UOP_T2:  begin mul_a = zx(q_reg[95:64]);  mul_b = zx(t2_reg); end
            UOP_T3:  begin mul_a = zx(q_reg[127:96]); mul_b = zx(t2_reg); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign mul_p_next = mul_a * mul_b;

    always_comb
    begin
        logic signed [ACC_W-1:0] p_ext;
        logic signed [ACC_W-1:0] sum;
        logic [WIDE_W-1:0]       pw;
        logic [WIDE_W-1:0]       rhs;

        p_ext = ACC_W'(mul_p_reg);
        sum   = acc_reg + p_ext;
        pw    = {{(WIDE_W-PRD_W){1'b0}}, mul_p_reg[PRD_W-1:0]};
        rhs   = wacc_reg + (pw << 96);

        segs_next  = segs_reg;
        thr_next   = thr_reg;
        index_next = index_reg;
        count_next = count_reg;
        hx_next = hx_reg; hy_next = hy_reg; hz_next = hz_reg;
        cx_next = cx_reg; cy_next = cy_reg; cz_next = cz_reg;
        last_next = last_reg;
        seg_next  = seg_reg;
        out_next  = out_reg;
        acc_next  = acc_reg;
        nx_next = nx_reg; ny_next = ny_reg; nz_next = nz_reg;
        na_next = na_reg; nb_next = nb_reg;
        cp_next   = cp_reg;
        mag_next  = mag_reg;
        wacc_next = wacc_reg;
        q_next    = q_reg;
        lhs_next  = lhs_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_SEGMENT_COUNT:      segs_next = cfg_data[SEGS_W-1:0];
                REG_PARALLEL_THRESHOLD: thr_next  = cfg_data[THR_W-1:0];
                default:                ;
            endcase
        end

        case (op_reg)
            UOP_NX0, UOP_NY0, UOP_NZ0, UOP_NA0, UOP_NB0, UOP_D0: acc_next = p_ext;
            UOP_NA1, UOP_NB1, UOP_D1: acc_next = sum;
            UOP_NX1: nx_next = NRM_W'(acc_reg - p_ext);
            UOP_NY1: ny_next = NRM_W'(acc_reg - p_ext);
            UOP_NZ1: nz_next = NRM_W'(acc_reg - p_ext);
            UOP_NA2: na_next = NSQ_W'(sum);
            UOP_NB2: nb_next = NSQ_W'(sum);
            UOP_PP:  cp_next = mul_p_reg[PRD_W-1:0];
            UOP_D2:  mag_next = sum[ACC_W-1] ? PRD_W'(-sum) : PRD_W'(sum);
            UOP_Q00, UOP_M00, UOP_T0: wacc_next = pw;
            UOP_Q01, UOP_Q10, UOP_M01, UOP_M10, UOP_T1: wacc_next = wacc_reg + (pw << 32);
            UOP_T2:  wacc_next = wacc_reg + (pw << 64);
            UOP_Q11: q_next = Q_W'(wacc_reg + (pw << 64));
            UOP_M11: lhs_next = (wacc_reg + (pw << 64)) << 30;
            UOP_T3:
            begin
                if (lhs_reg > rhs && count_reg != '1)
                    count_next = count_reg + CNT_W'(1);
            end
            default: ;
        endcase

        if (cmd.load)
        begin
            cx_next   = col_x;
            cy_next   = col_y;
            cz_next   = col_z;
            last_next = last_column;
            seg_next  = index_reg[SW:1];
            if (in_range && !index_reg[0])
            begin
                hx_next = col_x;
                hy_next = col_y;
                hz_next = col_z;
            end
            if (index_reg != '1)
                index_next = index_reg + IDX_W'(1);
        end

        if (cmd.emit)
        begin
            out_next   = count_reg;
            count_next = '0;
            index_next = '0;
            hx_next = '0; hy_next = '0; hz_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            segs_reg  <= SEGS_RESET;
            thr_reg   <= THR_RESET;
            index_reg <= '0;
            count_reg <= '0;
            hx_reg    <= '0;
            hy_reg    <= '0;
            hz_reg    <= '0;
            op_reg    <= UOP_NOP;
        end
        else
        begin
            segs_reg  <= segs_next;
            thr_reg   <= thr_next;
            index_reg <= index_next;
            count_reg <= count_next;
            hx_reg    <= hx_next;
            hy_reg    <= hy_next;
            hz_reg    <= hz_next;
            op_reg    <= cmd.uop;
        end
    end

    always_ff @(posedge clk)
    begin
        t2_reg    <= 32'(thr_reg * thr_reg);
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        cz_reg    <= cz_next;
        last_reg  <= last_next;
        seg_reg   <= seg_next;
        out_reg   <= out_next;
        mul_p_reg <= mul_p_next;
        acc_reg   <= acc_next;
        nx_reg    <= nx_next;
        ny_reg    <= ny_next;
        nz_reg    <= nz_next;
        na_reg    <= na_next;
        nb_reg    <= nb_next;
        cp_reg    <= cp_next;
        mag_reg   <= mag_next;
        wacc_reg  <= wacc_next;
        q_reg     <= q_next;
        lhs_reg   <= lhs_next;
        if (op_reg == UOP_WR)
        begin
            mem_nx[seg_reg] <= nx_reg;
            mem_ny[seg_reg] <= ny_reg;
            mem_nz[seg_reg] <= nz_reg;
            mem_p[seg_reg]  <= cp_reg;
        end
    end

endmodule

// ----- rtl/jpsc_ctrl.sv -----
// ----------------------------------------------------------------------------
// jpsc_ctrl
// Sequencer: column intake, micro-op issue per segment and pair, result slot.
// ----------------------------------------------------------------------------
module jpsc_ctrl
    import jpsc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  jpsc_status_t st,
    output jpsc_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_BUILD  = 5'b00010,
        S_CMP    = 5'b00100,
        S_DRAIN  = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [SEG_IDX_W-1:0] k_reg, k_next;
    logic                 out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        cmd.uop        = UOP_NOP;
        cmd.load       = 1'b0;
        cmd.emit       = 1'b0;
        cmd.k          = k_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = st.build ? S_BUILD : S_FINISH;
                end
            end
            S_BUILD:
            begin
                cmd.uop = build_uop(step_reg);
                if (step_reg == STEP_W'(SEQ_LEN - 1))
                begin
                    step_next  = '0;
                    k_next     = '0;
                    state_next = (st.seg == '0) ? S_DRAIN : S_CMP;
                end
                else
                    step_next = step_reg + STEP_W'(1);
            end
            S_CMP:
            begin
                cmd.uop = cmp_uop(step_reg);
                if (step_reg == STEP_W'(SEQ_LEN - 1))
                begin
                    step_next = '0;
                    if (k_reg + SEG_IDX_W'(1) == st.seg)
                        state_next = S_DRAIN;
                    else
                        k_next = k_reg + SEG_IDX_W'(1);
                end
                else
                    step_next = step_reg + STEP_W'(1);
            end
            // last compare lands in the count here
            S_DRAIN:
                state_next = S_FINISH;
            S_FINISH:
            begin
                if (!st.last)
                    state_next = S_IDLE;
                else if (!out_valid_reg || out_ready)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_cmp_below_seg: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (k_reg < st.seg))
        else $error("compare index reached current segment");

    a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("count emitted over a pending transfer");

    a_build_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BUILD && step_reg == '0) |-> $past(cmd.load))
        else $error("segment build started without a column");
`endif

endmodule

// ----- rtl/jacobian_plane_singularity_count_core.sv -----
// ----------------------------------------------------------------------------
// jacobian_plane_singularity_count_core
// Counts nearly parallel segment plane normals over the columns of a Jacobian.
// ----------------------------------------------------------------------------
// col takes one Q4.12 column per transfer; result gives pair_count once per
// Jacobian, on the column flagged last_column. cfg_we/cfg_index/cfg_data
// write segment_count (index 0) and parallel_threshold (index 1); the user
// must do so only while idle, as the block itself does not enforce it.
// Columns are taken one at a time. The second column of segment s is worked
// on the single shared 33x33 multiplier (15 micro-ops to build the normal
// and norm product, 15 per compare against each earlier segment). The count
// moves to the output register in the finish state after the last column's
// work; it is held until taken, and a further last column waits for the slot
// while earlier columns keep flowing in. Reset clears the column index, the
// held column, the count and the output slot, and loads segment_count = 3
// and parallel_threshold = 32604; the normal store needs no clearing.
// ----------------------------------------------------------------------------
module jacobian_plane_singularity_count_core
    import jpsc_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    jpsc_col_if.sink             col,
    jpsc_cnt_if.source           result
);

    jpsc_cmd_t    cmd;
    jpsc_status_t st;

    jpsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (col.valid),
        .in_ready  (col.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .st        (st),
        .cmd       (cmd)
    );

    jpsc_datapath #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .col_x       (col.col_x),
        .col_y       (col.col_y),
        .col_z       (col.col_z),
        .last_column (col.last_column),
        .cmd         (cmd),
        .st          (st),
        .pair_count  (result.pair_count)
    );

endmodule

// ----- bench/tb_jacobian_plane_singularity_count_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_jacobian_plane_singularity_count_core
// Feeds a directed table and then random frames over several settings through
// the valid/ready Jacobian column channel; checks each pair count against a
// cycle-free model of the parallel-normal test or the count of a typed row.
// ----------------------------------------------------------------------------
module tb_jacobian_plane_singularity_count_core
    import jpsc_pkg::*;
();

    localparam int MAX_SEGS   = 8;
    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_LEN   = 400;
    localparam int DRAIN_WAIT = 250;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        bit                 last;
        bit                 typed;
        logic [4:0]         count;
    } col_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    cfg_reg_t cfg_index;
    logic [CFG_W-1:0] cfg_data;

    jpsc_col_if col ();
    jpsc_cnt_if result ();

    jacobian_plane_singularity_count_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .col       (col),
        .result    (result)
    );

    // model state
    logic [3:0]  seg_setting;
    logic [15:0] thr_setting;
    int          col_pos;
    longint      held_x, held_y, held_z;
    longint      nrm_x [MAX_SEGS];
    longint      nrm_y [MAX_SEGS];
    longint      nrm_z [MAX_SEGS];
    logic [63:0] nrm_prod [MAX_SEGS];
    logic [4:0]  pair_tally;

    logic [4:0] expected_counts [$];
    int  errors;
    int  cols_sent;
    int  counts_seen;
    int  idle_cycles;
    bit  hold_done;
    bit  stim_done;

    col_row_t directed [] = '{
        '{16'sd4096, 16'sd0, 16'sd0, 1'b0, 1'b0, 5'd0},
        '{16'sd0, 16'sd4096, 16'sd0, 1'b0, 1'b0, 5'd0},
        '{16'sd8192, 16'sd0, 16'sd0, 1'b0, 1'b0, 5'd0},
        '{16'sd0, -16'sd4096, 16'sd0, 1'b0, 1'b0, 5'd0},
        '{16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, 5'd0},
        '{16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1, 5'd1},
        '{16'sd4096, 16'sd0, 16'sd0, 1'b1, 1'b1, 5'd0},
        '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, 1'b0, 5'd0},
        '{16'sd32767, -16'sd32768, 16'sd32767, 1'b0, 1'b0, 5'd0},
        '{-16'sd32768, 16'sd32767, -16'sd32768, 1'b0, 1'b0, 5'd0},
        '{16'sd32767, 16'sd32767, -16'sd32768, 1'b0, 1'b0, 5'd0},
        '{16'sd32767, 16'sd32767, 16'sd32767, 1'b0, 1'b0, 5'd0},
        '{-16'sd1, -16'sd1, -16'sd1, 1'b0, 1'b0, 5'd0},
        '{16'sd1, 16'sd0, -16'sd1, 1'b0, 1'b0, 5'd0},
        '{-16'sd32768, 16'sd0, 16'sd32767, 1'b1, 1'b0, 5'd0},
        '{16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1, 5'd0},
        '{16'sd100, 16'sd200, 16'sd300, 1'b0, 1'b0, 5'd0},
        '{-16'sd5, 16'sd7, 16'sd11, 1'b0, 1'b0, 5'd0},
        '{16'sd100, 16'sd200, 16'sd300, 1'b0, 1'b0, 5'd0},
        '{-16'sd5, 16'sd7, 16'sd11, 1'b1, 1'b0, 5'd0}
    };

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    task automatic report_mismatch(input string what, input logic [4:0] got,
                                   input logic [4:0] want);
        errors++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // exact squared test: (ni.nj)^2 * 2^30 > thr^2 * Pi * Pj
    function automatic bit normals_parallel(input int i, input int j);
        logic signed [67:0] dot;
        logic [191:0] mag, lhs, rhs, pi, pj, t;
        dot = 68'(nrm_x[i]) * 68'(nrm_x[j]) + 68'(nrm_y[i]) * 68'(nrm_y[j])
            + 68'(nrm_z[i]) * 68'(nrm_z[j]);
        mag = (dot < 0) ? 192'(-dot) : 192'(dot);
        pi  = 192'(nrm_prod[i]);
        pj  = 192'(nrm_prod[j]);
        t   = 192'(thr_setting);
        lhs = (mag * mag) << 30;
        rhs = pi * pj * t * t;
        return lhs > rhs;
    endfunction

    // advances the model by one column, returns 1 when a count is produced
    function automatic bit count_column(input logic signed [15:0] x,
                                        input logic signed [15:0] y,
                                        input logic signed [15:0] z,
                                        input bit last, output logic [4:0] count);
        int segs;
        int s;
        longint cx, cy, cz;
        logic [63:0] na, nb;
        segs = (seg_setting > MAX_SEGS) ? MAX_SEGS : int'(seg_setting);
        cx = longint'(x);
        cy = longint'(y);
        cz = longint'(z);
        count = '0;
        if (col_pos < 2 * segs)
        begin
            if (col_pos % 2 == 0)
            begin
                held_x = cx;
                held_y = cy;
                held_z = cz;
            end
            else
            begin
                s = col_pos / 2;
                na = held_x * held_x + held_y * held_y + held_z * held_z;
                nb = cx * cx + cy * cy + cz * cz;
                nrm_x[s] = held_y * cz - held_z * cy;
                nrm_y[s] = held_z * cx - held_x * cz;
                nrm_z[s] = held_x * cy - held_y * cx;
                nrm_prod[s] = na * nb;
                for (int k = 0; k < s; k++)
                    if (normals_parallel(k, s) && pair_tally < 5'd31)
                        pair_tally++;
            end
        end
        if (col_pos < 31)
            col_pos++;
        if (last)
        begin
            count = pair_tally;
            col_pos = 0;
            held_x = 0;
            held_y = 0;
            held_z = 0;
            pair_tally = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic send_column(input col_row_t row);
        int r, gap;
        logic [4:0] cnt;
        r = $urandom_range(0, 99);
        gap = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap > 0)
        begin
            col.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        col.valid       <= 1'b1;
        col.col_x       <= row.x;
        col.col_y       <= row.y;
        col.col_z       <= row.z;
        col.last_column <= row.last;
        @(posedge clk);
        while (!col.ready)
            @(posedge clk);
        if (count_column(row.x, row.y, row.z, row.last, cnt))
            expected_counts.push_back(row.typed ? row.count : cnt);
        cols_sent++;
        @(negedge clk);
    endtask

    task automatic drain_and_settle();
        col.valid <= 1'b0;
        while (expected_counts.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_SEGMENT_COUNT)
            seg_setting = value[3:0];
        else
            thr_setting = value;
        @(negedge clk);
    endtask

    function automatic logic [15:0] extreme_value();
        case ($urandom_range(0, 3))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            default: return 16'hffff;
        endcase
    endfunction

    // frames mostly full length, with columns often reused so normals line up
    task automatic send_frames(input int n_cols);
        col_row_t frame [40];
        int segs, len, src, r;
        logic signed [15:0] sc;
        int sent;
        sent = 0;
        while (sent < n_cols)
        begin
            segs = (seg_setting > MAX_SEGS) ? MAX_SEGS : int'(seg_setting);
            if (segs == 0 || $urandom_range(0, 4) == 0)
                len = $urandom_range(1, 2 * segs + 3);
            else
                len = 2 * segs;
            for (int c = 0; c < len; c++)
            begin
                r = $urandom_range(0, 9);
                if (r == 0)
                begin
                    frame[c].x = '0;
                    frame[c].y = '0;
                    frame[c].z = '0;
                end
                else if (r == 1)
                begin
                    frame[c].x = extreme_value();
                    frame[c].y = extreme_value();
                    frame[c].z = extreme_value();
                end
                else if (r < 6 && c >= 2)
                begin
                    src = $urandom_range(0, c - 1);
                    sc = $urandom_range(0, 1) ? 16'sd1 : -16'sd1;
                    frame[c].x = 16'(frame[src].x * sc + $urandom_range(0, 2) - 1);
                    frame[c].y = 16'(frame[src].y * sc + $urandom_range(0, 2) - 1);
                    frame[c].z = 16'(frame[src].z * sc);
                end
                else
                begin
                    frame[c].x = 16'($urandom);
                    frame[c].y = 16'($urandom);
                    frame[c].z = 16'($urandom);
                end
                frame[c].last  = (c == len - 1);
                frame[c].typed = 1'b0;
                frame[c].count = '0;
            end
            for (int c = 0; c < len; c++)
                send_column(frame[c]);
            sent += len;
        end
    endtask

    // result side: random stalls, plus one long hold-off to back up the input
    initial
    begin
        int stall;
        stall = 0;
        hold_done = 1'b0;
        result.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && counts_seen >= 6)
            begin
                result.ready <= 1'b0;
                repeat (HOLD_LEN) @(negedge clk);
                hold_done = 1'b1;
            end
            else if (stall > 0)
            begin
                result.ready <= 1'b0;
                stall--;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                result.ready <= 1'b0;
                stall = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                                     : $urandom_range(0, 3);
            end
            else
                result.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready)
        begin
            counts_seen++;
            if (expected_counts.size() == 0)
                report_mismatch("unexpected transfer", result.pair_count, 5'd0);
            else if (result.pair_count !== expected_counts[0])
                report_mismatch("pair_count", result.pair_count, expected_counts.pop_front());
            else
                void'(expected_counts.pop_front());
        end
    end

    always @(posedge clk)
    begin
        if ((col.valid && col.ready) || (result.valid && result.ready) || stim_done)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        logic [3:0]  seg_plan [8];
        logic [15:0] thr_plan [8];
        seg_plan = '{4'd1, 4'd8, 4'd15, 4'd0, 4'd8, 4'd2, 4'd6, 4'd4};
        thr_plan = '{16'd0, 16'd32767, 16'd65535, 16'd100,
                     16'd0, 16'd32768, 16'd30000, 16'd32604};
        errors = 0;
        cols_sent = 0;
        counts_seen = 0;
        idle_cycles = 0;
        stim_done = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_SEGMENT_COUNT;
        cfg_data = '0;
        col.valid = 1'b0;
        col.col_x = '0;
        col.col_y = '0;
        col.col_z = '0;
        col.last_column = 1'b0;
        seg_setting = SEGS_RESET;
        thr_setting = THR_RESET;
        col_pos = 0;
        held_x = 0;
        held_y = 0;
        held_z = 0;
        pair_tally = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[i])
            send_column(directed[i]);
        drain_and_settle();

        for (int p = 0; p < 8; p++)
        begin
            write_reg(REG_SEGMENT_COUNT, {12'd0, seg_plan[p]});
            write_reg(REG_PARALLEL_THRESHOLD, thr_plan[p]);
            send_frames(115);
            drain_and_settle();
        end
        stim_done = 1'b1;

        $display("covered %0d columns and %0d pair counts over 9 register settings",
                 cols_sent, counts_seen);
        $display("including zero, early-last, extra-column and saturated-setting cases");
        if (errors == 0 && expected_counts.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
